>>> src/efnq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efnq_pkg
// Shared widths, operation codes and record layout for the event flag queue.
// ----------------------------------------------------------------------------
package efnq_pkg;

  localparam int NUM_EVENTS    = 16;
  localparam int CONSUMER_BITS = 8;

  localparam int IDX_W  = $clog2(NUM_EVENTS);
  localparam int CNT_W  = $clog2(NUM_EVENTS + 1);
  localparam int FLAG_W = 32;
  localparam int CID_W  = 8;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 48;

  // Operation codes carried on the input tuser.
  localparam logic [2:0] KIND_INIT  = 3'd0;
  localparam logic [2:0] KIND_SET   = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_POP   = 3'd4;

  typedef struct packed {
    logic [FLAG_W-1:0]        flags;
    logic [CONSUMER_BITS-1:0] cid;
    logic                     present;
  } rec_t;

endpackage

>>> src/event_flag_notify_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flag_notify_queue_top
// Event flag records with a duplicate-free queue of pending consumers.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one operation per item: tuser holds the kind
//   (init, set bits, clear bits, read bits, pop next consumer) and tdata holds
//   the record index, bit mask, consumer id and consumer-given flag. Every
//   item produces exactly one result item on the master stream holding the
//   old flag word, the popped consumer with its valid flag, and whether the
//   pending queue still holds entries.
//   Records live in one synchronous memory with a registered read. An item is
//   read in the cycle it is accepted; its write back, if any, and its result
//   follow together once the output register is free. A pop on a non-empty
//   queue first reads the queue memory at the head and then the record it
//   names, and only then writes its result.
//   One item is in flight at a time: the input takes a new item once the
//   previous result sits in the output register.
//   If the receiver stalls, the finished result is held in the output
//   register; the next item may still be accepted and read, but its write
//   back waits until the output register is free.
//   Reset (synchronous, active high) clears the per-record valid bits, the
//   queued marks and the queue pointers, so every record reads as zero; no
//   clearing pass is needed. The queue memory itself is not cleared.
// ----------------------------------------------------------------------------
module event_flag_notify_queue_top (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: event_index[3:0], bit_mask[35:4], consumer_id[43:36],
  // consumer_given[44], zero fill[47:45]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [efnq_pkg::IN_DATA_W-1:0] s_tdata,
  // s_tuser: kind[2:0]
  input  logic [efnq_pkg::IN_USER_W-1:0] s_tuser,
  // m_tdata: old_bits[31:0], popped_valid[32], popped_consumer[40:33],
  // queue_not_empty[41], zero fill[47:42]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [efnq_pkg::OUT_DATA_W-1:0] m_tdata
);
  import efnq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_REC, S_FIFO, S_POP} state_t;

  state_t state;

  // Latched operation.
  logic [2:0]               op_kind;
  logic [IDX_W-1:0]         op_idx;
  logic [FLAG_W-1:0]        op_mask;
  logic [CONSUMER_BITS-1:0] op_cid;
  logic                     op_given;
  logic                     op_ok;

  // Storage.
  rec_t                     rec_mem [NUM_EVENTS];
  logic [NUM_EVENTS-1:0]    rec_valid;
  logic [NUM_EVENTS-1:0]    queued;
  logic [IDX_W-1:0]         fifo_mem [NUM_EVENTS];
  logic [IDX_W-1:0]         fifo_head;
  logic [IDX_W-1:0]         fifo_tail;
  logic [CNT_W-1:0]         fifo_count;

  // Read data registers.
  rec_t                     rec_q;
  logic                     rec_vld_q;
  logic [IDX_W-1:0]         fifo_q;

  logic                     accept;
  logic                     out_free;
  logic [IDX_W-1:0]         in_idx;
  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_en;
  rec_t                     rec_eff;
  logic                     in_ok;

  // Write-back and result logic.
  logic                     rec_we;
  logic [IDX_W-1:0]         rec_waddr;
  rec_t                     rec_wdata;
  logic                     enq;
  logic                     deq;
  logic [FLAG_W-1:0]        res_old;
  logic                     res_pv;
  logic [CID_W-1:0]         res_pc;
  logic                     finish;
  logic [CNT_W-1:0]         count_next;
  logic [IDX_W-1:0]         head_next;
  logic [IDX_W-1:0]         tail_next;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_idx   = s_tdata[IDX_W-1:0];
  assign in_ok    = 32'(s_tdata[3:0]) < NUM_EVENTS;
  assign rec_eff  = rec_vld_q ? rec_q : '0;

  // The record port is read at the item's index on acceptance, or at the
  // queue entry once it has come out of the queue memory.
  always_comb begin
    rd_addr = in_idx;
    rd_en   = accept;
    if (state == S_FIFO) begin
      rd_addr = fifo_q;
      rd_en   = 1'b1;
    end
  end

  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = op_idx;
    rec_wdata = rec_eff;
    enq       = 1'b0;
    deq       = 1'b0;
    res_old   = '0;
    res_pv    = 1'b0;
    res_pc    = '0;
    finish    = 1'b0;
    if (state == S_REC && out_free) begin
      finish = 1'b1;
      if (op_ok) begin
        case (op_kind)
          KIND_INIT: begin
            rec_we            = 1'b1;
            rec_wdata.flags   = '0;
            rec_wdata.present = op_given;
            rec_wdata.cid     = op_given ? op_cid : '0;
          end
          KIND_SET, KIND_CLEAR: begin
            rec_we          = 1'b1;
            res_old         = rec_eff.flags;
            rec_wdata.flags = (op_kind == KIND_SET) ? (rec_eff.flags | op_mask)
                                                    : (rec_eff.flags & ~op_mask);
            enq = rec_eff.present && !queued[op_idx] &&
                  (32'(fifo_count) < NUM_EVENTS);
          end
          KIND_READ: begin
            res_old = rec_eff.flags;
          end
          default: begin
          end
        endcase
      end
    end else if (state == S_POP && out_free) begin
      finish    = 1'b1;
      deq       = 1'b1;
      rec_waddr = fifo_q;
      res_pv    = rec_eff.present;
      res_pc    = rec_eff.present ? CID_W'(rec_eff.cid) : '0;
    end
  end

  always_comb begin
    head_next  = (32'(fifo_head) + 1 >= NUM_EVENTS) ? '0 : fifo_head + 1'b1;
    tail_next  = (32'(fifo_tail) + 1 >= NUM_EVENTS) ? '0 : fifo_tail + 1'b1;
    count_next = fifo_count;
    if (enq) begin
      count_next = fifo_count + 1'b1;
    end else if (deq) begin
      count_next = fifo_count - 1'b1;
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rec_q     <= rec_mem[rd_addr];
      rec_vld_q <= rec_valid[rd_addr];
    end
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (accept) begin
      fifo_q <= fifo_mem[fifo_head];
    end
    if (enq) begin
      fifo_mem[fifo_tail] <= op_idx;
    end
  end

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rec_valid  <= '0;
      queued     <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == KIND_POP && fifo_count != '0) begin
              state <= S_FIFO;
            end else begin
              state <= S_REC;
            end
          end
        end
        S_FIFO: begin
          state <= S_POP;
        end
        S_REC, S_POP: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (rec_we) begin
        rec_valid[rec_waddr] <= 1'b1;
      end
      if (enq) begin
        queued[op_idx] <= 1'b1;
        fifo_tail      <= tail_next;
      end
      if (deq) begin
        queued[fifo_q] <= 1'b0;
        fifo_head      <= head_next;
      end
      fifo_count <= count_next;
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind  <= s_tuser;
      op_idx   <= in_idx;
      op_mask  <= s_tdata[35:4];
      op_cid   <= s_tdata[36 +: CONSUMER_BITS];
      op_given <= s_tdata[44];
      op_ok    <= in_ok;
    end
    if (finish) begin
      m_tdata <= {6'b0, (count_next != '0), res_pc, res_pv, res_old};
    end
  end

  // The queue never exceeds the number of records.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fifo_count) <= NUM_EVENTS)
    else $error("pending queue count exceeds record count");

  // Each queued record is marked exactly once.
  a_marks_match: assert property (@(posedge clk) disable iff (rst)
    $countones(queued) == 32'(fifo_count))
    else $error("queued marks disagree with queue count");

  // Only one item is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second item accepted while one is in flight");

  // A pop result never carries a flag word.
  a_pop_no_flags: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[32]) |-> (m_tdata[31:0] == '0))
    else $error("popped result carries flag bits");

  // A result is only produced when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("stalled result overwritten");

endmodule

>>> sim/tb_event_flag_notify_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_flag_notify_queue_top
// Self-checking bench for the event flag records and their pending queue.
// ----------------------------------------------------------------------------
// Every accepted operation is run through a cycle-free software copy of the
// record table and the pending queue, and the result it gives is queued.
// Each result item leaving the block is compared field by field with the
// oldest queued result. The stimulus starts with hand-picked operations,
// then fills the queue to its depth, stalls the output for a long stretch
// and finishes with weighted random traffic. Both stream sides insert
// random idle gaps per item.
// ----------------------------------------------------------------------------
module tb_event_flag_notify_queue_top;
  import efnq_pkg::*;

  // Kinds that the block must ignore.
  localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

  localparam int MAX_GAP     = 18;
  localparam int LONG_HOLD   = 250;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [2:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [FLAG_W-1:0] mask;
    logic [CID_W-1:0]  cid;
    logic              given;
  } event_op_t;

  typedef struct {
    logic [FLAG_W-1:0] old_bits;
    logic              popped_valid;
    logic [CID_W-1:0]  popped_consumer;
    logic              queue_not_empty;
  } event_res_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  event_flag_notify_queue_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // Software copy of the record table and the pending queue.
  logic [FLAG_W-1:0]        rec_flags   [NUM_EVENTS];
  logic [CONSUMER_BITS-1:0] rec_cid     [NUM_EVENTS];
  bit                       rec_present [NUM_EVENTS];
  bit                       rec_queued  [NUM_EVENTS];
  logic [IDX_W-1:0]         pend_slots  [NUM_EVENTS];
  int                       pend_head;
  int                       pend_tail;
  int                       pend_count;

  event_res_t expected_results [$];
  event_res_t oldest;

  int send_gap_max = MAX_GAP;
  int recv_gap_max = MAX_GAP;
  int hold_cycles  = 0;

  int ops_sent         = 0;
  int results_seen     = 0;
  int consumers_popped = 0;
  int mismatches       = 0;
  int idle_cycles      = 0;

  // Applies one operation to the software table and returns its result.
  function automatic event_res_t apply_event_op(event_op_t op);
    event_res_t r;
    int e;
    r.old_bits        = '0;
    r.popped_valid    = 1'b0;
    r.popped_consumer = '0;
    case (op.kind)
      KIND_INIT: begin
        // The queued mark is left alone, so a queued record stays queued.
        rec_present[op.idx] = op.given;
        rec_cid[op.idx]     = op.given ? op.cid[CONSUMER_BITS-1:0] : '0;
        rec_flags[op.idx]   = '0;
      end
      KIND_SET, KIND_CLEAR: begin
        r.old_bits = rec_flags[op.idx];
        rec_flags[op.idx] = (op.kind == KIND_SET) ? (r.old_bits | op.mask)
                                                  : (r.old_bits & ~op.mask);
        if (rec_present[op.idx] && !rec_queued[op.idx] && pend_count < NUM_EVENTS) begin
          pend_slots[pend_tail] = op.idx;
          pend_tail = (pend_tail + 1) % NUM_EVENTS;
          pend_count++;
          rec_queued[op.idx] = 1'b1;
        end
      end
      KIND_READ: r.old_bits = rec_flags[op.idx];
      KIND_POP: begin
        if (pend_count != 0) begin
          e = int'(pend_slots[pend_head]);
          pend_head = (pend_head + 1) % NUM_EVENTS;
          pend_count--;
          rec_queued[e] = 1'b0;
          // A record whose consumer was removed leaves the queue silently.
          if (rec_present[e]) begin
            r.popped_valid    = 1'b1;
            r.popped_consumer = rec_cid[e];
          end
        end
      end
      default: ;
    endcase
    r.queue_not_empty = (pend_count != 0);
    return r;
  endfunction

  function automatic event_op_t make_op(logic [2:0] kind, logic [IDX_W-1:0] idx,
                                        logic [FLAG_W-1:0] mask, logic [CID_W-1:0] cid,
                                        logic given);
    event_op_t op;
    op.kind  = kind;
    op.idx   = idx;
    op.mask  = mask;
    op.cid   = cid;
    op.given = given;
    return op;
  endfunction

  function automatic logic [FLAG_W-1:0] random_mask();
    logic [FLAG_W-1:0] m;
    case ($urandom_range(0, 7))
      0:       m = '1;
      1:       m = '0;
      2:       m = 32'h1 << $urandom_range(0, FLAG_W - 1);
      default: m = $urandom;
    endcase
    return m;
  endfunction

  // Weighted mix: mostly set, clear and pop so that the queue keeps moving.
  function automatic event_op_t random_op();
    event_op_t op;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      op.kind = KIND_INIT;
    else if (pick < 40) op.kind = KIND_SET;
    else if (pick < 60) op.kind = KIND_CLEAR;
    else if (pick < 73) op.kind = KIND_READ;
    else if (pick < 97) op.kind = KIND_POP;
    else                op.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    op.idx   = IDX_W'(($urandom_range(0, 9) < 3) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, NUM_EVENTS - 1));
    op.mask  = random_mask();
    op.cid   = CID_W'($urandom_range(0, (1 << CID_W) - 1));
    op.given = ($urandom_range(0, 6) != 0);
    return op;
  endfunction

  // Offers one item after a random gap and waits until it is taken. The
  // valid stays high afterwards so back-to-back items see no gap in valid.
  task automatic send_op(input event_op_t op);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op.kind;
    s_tdata  <= {3'b0, op.given, op.cid, op.mask, op.idx};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(apply_event_op(op));
    ops_sent++;
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input logic [FLAG_W-1:0] got,
                                 input logic [FLAG_W-1:0] want);
    if (mismatches < MAX_REPORTS)
      $display("Mismatch at result %0d: %s is %h, expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Output sink: a random gap per item, or a long hold when one is requested.
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, recv_gap_max);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Result checker. m_tdata: old_bits[31:0], popped_valid[32],
  // popped_consumer[40:33], queue_not_empty[41].
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding, old_bits", m_tdata[31:0], '0);
      end else begin
        oldest = expected_results.pop_front();
        if (m_tdata[31:0] !== oldest.old_bits)
          report_mismatch("old_bits", m_tdata[31:0], oldest.old_bits);
        if (m_tdata[32] !== oldest.popped_valid)
          report_mismatch("popped_valid", FLAG_W'(m_tdata[32]),
                          FLAG_W'(oldest.popped_valid));
        if (m_tdata[40:33] !== oldest.popped_consumer)
          report_mismatch("popped_consumer", FLAG_W'(m_tdata[40:33]),
                          FLAG_W'(oldest.popped_consumer));
        if (m_tdata[41] !== oldest.queue_not_empty)
          report_mismatch("queue_not_empty", FLAG_W'(m_tdata[41]),
                          FLAG_W'(oldest.queue_not_empty));
      end
      if (m_tdata[32] === 1'b1) consumers_popped++;
      results_seen++;
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed_cases();
    // Full set, partial clear, zero mask; a set on a queued record adds nothing.
    send_op(make_op(KIND_INIT,  4'd0,  '0,           8'hFF, 1'b1));
    send_op(make_op(KIND_SET,   4'd0,  32'hFFFFFFFF, 8'h00, 1'b0));
    send_op(make_op(KIND_READ,  4'd0,  '0,           8'h00, 1'b0));
    send_op(make_op(KIND_CLEAR, 4'd0,  32'hAAAAAAAA, 8'h00, 1'b0));
    send_op(make_op(KIND_READ,  4'd0,  '0,           8'h00, 1'b0));
    send_op(make_op(KIND_SET,   4'd0,  32'h00000000, 8'h00, 1'b0));
    send_op(make_op(KIND_POP,   4'd9,  32'hFFFFFFFF, 8'hFF, 1'b1));
    // Pop of an empty queue.
    send_op(make_op(KIND_POP,   4'd0,  '0,           8'h00, 1'b0));
    // Consumer removed while queued: the pop drops the record without a consumer.
    send_op(make_op(KIND_INIT,  4'd15, '0,           8'h00, 1'b1));
    send_op(make_op(KIND_SET,   4'd15, 32'h80000001, 8'h00, 1'b0));
    send_op(make_op(KIND_INIT,  4'd15, 32'hFFFFFFFF, 8'hA5, 1'b0));
    send_op(make_op(KIND_READ,  4'd15, '0,           8'h00, 1'b0));
    send_op(make_op(KIND_POP,   4'd15, '0,           8'h00, 1'b0));
    // Record without a consumer: flags change but nothing is queued.
    send_op(make_op(KIND_SET,   4'd3,  32'h12345678, 8'h00, 1'b0));
    send_op(make_op(KIND_CLEAR, 4'd3,  32'h0000FFFF, 8'h00, 1'b0));
    send_op(make_op(KIND_POP,   4'd3,  '0,           8'h00, 1'b0));
    // Unused kinds must leave every record alone.
    send_op(make_op(KIND_SPARE_LO,  4'd3, 32'hFFFFFFFF, 8'hFF, 1'b1));
    send_op(make_op(KIND_SPARE_MID, 4'd3, 32'hFFFFFFFF, 8'hFF, 1'b1));
    send_op(make_op(KIND_SPARE_HI,  4'd3, 32'hFFFFFFFF, 8'hFF, 1'b1));
    // Re-init of a queued record keeps it queued and the pop sees the new id.
    send_op(make_op(KIND_INIT,  4'd7,  '0,           8'h3C, 1'b1));
    send_op(make_op(KIND_CLEAR, 4'd7,  32'hFFFFFFFF, 8'h00, 1'b0));
    send_op(make_op(KIND_INIT,  4'd7,  '0,           8'hC3, 1'b1));
    send_op(make_op(KIND_SET,   4'd7,  32'h00000000, 8'h00, 1'b0));
    send_op(make_op(KIND_POP,   4'd7,  '0,           8'h00, 1'b0));
    send_op(make_op(KIND_POP,   4'd7,  '0,           8'h00, 1'b0));
  endtask

  // Every record gets a consumer and a set, so the queue reaches its depth;
  // further clears must not add duplicates, and the last pop finds it empty.
  task automatic test_full_queue();
    int order [NUM_EVENTS];
    int j;
    int t;
    for (int i = 0; i < NUM_EVENTS; i++) order[i] = i;
    for (int i = NUM_EVENTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NUM_EVENTS; i++)
      send_op(make_op(KIND_INIT, IDX_W'(order[i]), random_mask(),
                      CID_W'($urandom_range(0, 255)), 1'b1));
    for (int i = 0; i < NUM_EVENTS; i++)
      send_op(make_op(KIND_SET, IDX_W'(order[i]), random_mask(),
                      CID_W'($urandom_range(0, 255)), 1'b0));
    repeat (4)
      send_op(make_op(KIND_CLEAR, IDX_W'($urandom_range(0, NUM_EVENTS - 1)), random_mask(),
                      CID_W'($urandom_range(0, 255)), 1'b1));
    repeat (NUM_EVENTS + 1)
      send_op(make_op(KIND_POP, IDX_W'($urandom_range(0, NUM_EVENTS - 1)), random_mask(),
                      CID_W'($urandom_range(0, 255)), 1'b1));
  endtask

  // The sink holds off for a long stretch while items keep coming, so the
  // block fills up and drops s_tready; then the sender waits for every result.
  task automatic test_backpressure();
    send_gap_max = 0;
    hold_cycles  = LONG_HOLD;
    repeat (40) send_op(random_op());
    pause_until_drained();
    send_gap_max = MAX_GAP;
  endtask

  task automatic test_random_traffic();
    int gap_steps [3] = '{0, 4, MAX_GAP};
    for (int chunk = 0; chunk < 17; chunk++) begin
      send_gap_max = gap_steps[$urandom_range(0, 2)];
      recv_gap_max = gap_steps[$urandom_range(0, 2)];
      repeat (100) send_op(random_op());
      if ($urandom_range(0, 3) == 0) pause_until_drained();
    end
    send_gap_max = MAX_GAP;
    recv_gap_max = MAX_GAP;
  endtask

  initial begin : test_sequence
    for (int i = 0; i < NUM_EVENTS; i++) begin
      rec_flags[i]   = '0;
      rec_cid[i]     = '0;
      rec_present[i] = 1'b0;
      rec_queued[i]  = 1'b0;
    end
    pend_head  = 0;
    pend_tail  = 0;
    pend_count = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_full_queue();
    test_backpressure();
    test_random_traffic();

    pause_until_drained();
    repeat (8) @(posedge clk);

    $display("Checked %0d results for %0d operations; %0d pops returned a consumer.",
             results_seen, ops_sent, consumers_popped);
    $display("Covered all kinds, a full pending queue and a %0d-cycle output stall.",
             LONG_HOLD);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
